### design/rsx_pkg.sv
// rsx_pkg: shared types, constants and helpers for the reservoir sampler
// no dependencies; imported by every design module of the block
`timescale 1ns / 1ps

package rsx_pkg;

  // fixed field widths
  localparam int DATA_W     = 64;
  localparam int CAP_W      = 5;
  localparam int SLOT_W     = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int SLOT_EXT_W = 9;   // holds any slot index up to 256
  localparam int HALF_W     = DATA_W / 2;
  localparam int DIV_CNT_W  = $clog2(DATA_W);

  localparam int DEFAULT_MAX_SLOTS = 16;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SEED     = 2'd1;

  // item kinds
  localparam logic KIND_OBSERVE = 1'b0;
  localparam logic KIND_READ    = 1'b1;

  // splitmix64 constants
  localparam logic [DATA_W-1:0] MIX_GOLDEN = 64'h9e3779b97f4a7c15;
  localparam logic [DATA_W-1:0] MIX_MUL1   = 64'hbf58476d1ce4e5b9;
  localparam logic [DATA_W-1:0] MIX_MUL2   = 64'h94d049bb133111eb;

  // xoshiro256** shift and rotate amounts
  localparam int XO_SHIFT = 17;
  localparam int XO_ROT   = 45;

  typedef enum logic [3:0] {
    ST_SEED_ADD,
    ST_SEED_M1GO,
    ST_SEED_M1WAIT,
    ST_SEED_M2GO,
    ST_SEED_M2WAIT,
    ST_IDLE,
    ST_DRAW,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_DONE
  } rsx_state_e;

  typedef struct packed {
    logic [DATA_W-1:0] stamp;
    logic [DATA_W-1:0] word;
  } slot_entry_t;

  function automatic logic [DATA_W-1:0] rotl64(input logic [DATA_W-1:0] v, input int r);
    rotl64 = (v << r) | (v >> (DATA_W - r));
  endfunction

endpackage

### design/rsx_mul64lo.sv
// rsx_mul64lo: low 64 bits of a 64x64 product, built from one 32x32 multiplier
// used over three partial products; depends on rsx_pkg
`timescale 1ns / 1ps

module rsx_mul64lo (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [rsx_pkg::DATA_W-1:0] a_i,
  input  logic [rsx_pkg::DATA_W-1:0] b_i,
  output logic                      done_o,
  output logic [rsx_pkg::DATA_W-1:0] prod_o
);
  import rsx_pkg::*;

  logic [DATA_W-1:0] a_q, b_q, acc_q, prod_q;
  logic [1:0]        cnt_q;
  logic              busy_q, done_q;
  logic [HALF_W-1:0] op_a, op_b;
  logic [DATA_W-1:0] addend;

  // partial product select: low*low, low*high, high*low
  always_comb begin
    case (cnt_q)
      2'd0: begin
        op_a = a_q[HALF_W-1:0];
        op_b = b_q[HALF_W-1:0];
      end
      2'd1: begin
        op_a = a_q[HALF_W-1:0];
        op_b = b_q[DATA_W-1:HALF_W];
      end
      2'd2: begin
        op_a = a_q[DATA_W-1:HALF_W];
        op_b = b_q[HALF_W-1:0];
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  // first product lands unshifted, cross products go to the upper half
  assign addend = (cnt_q == 2'd1) ? prod_q : {prod_q[HALF_W-1:0], {HALF_W{1'b0}}};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 2'd1;
      if (cnt_q == 2'd3) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= a_i;
      b_q   <= b_i;
      acc_q <= '0;
    end else if (busy_q) begin
      if (cnt_q != 2'd3) begin
        prod_q <= op_a * op_b;
      end
      if (cnt_q != 2'd0) begin
        acc_q <= acc_q + addend;
      end
    end
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

### design/rsx_divider.sv
// rsx_divider: radix-2 restoring remainder unit, one dividend bit per cycle
// depends on rsx_pkg
`timescale 1ns / 1ps

module rsx_divider (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [rsx_pkg::DATA_W-1:0] dividend_i,
  input  logic [rsx_pkg::DATA_W-1:0] divisor_i,
  output logic                      done_o,
  output logic [rsx_pkg::DATA_W-1:0] rem_o
);
  import rsx_pkg::*;

  logic [DATA_W-1:0]    rem_q, dvd_q, dvs_q, rem_next;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic                 busy_q, done_q;
  logic [DATA_W:0]      trial, diff;

  assign trial    = {rem_q, dvd_q[DATA_W-1]};
  assign diff     = trial - {1'b0, dvs_q};
  assign rem_next = diff[DATA_W] ? trial[DATA_W-1:0] : diff[DATA_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == DIV_CNT_W'(DATA_W - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      dvd_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_next;
      dvd_q <= {dvd_q[DATA_W-2:0], 1'b0};
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

  // the remainder is below the divisor when done
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> rem_q < dvs_q)
    else $error("remainder not below divisor");

  // done only follows a running division
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(done_q) |-> $past(busy_q))
    else $error("done without division");

  // a started division runs
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |=> busy_q && !done_q)
    else $error("division did not start");

endmodule

### design/reservoir_sampler_xoshiro_top.sv
// reservoir_sampler_xoshiro_top: reservoir sample (algorithm r) with a
// xoshiro256** generator; uses rsx_pkg, rsx_mul64lo, rsx_divider
`timescale 1ns / 1ps
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+--------------------------------------
//  in       | in_valid_i / in_stall_o    | kind, timestamp, payload, has_data,
//           |                            | slot_index
//  out      | out_valid_o / out_stall_i  | stored, written_slot, fill_level,
//           |                            | read_valid, read_time, read_data
//  cfg      | cfg_we_i (no back-pressure)| cfg_index_i, cfg_wdata_i
//
//  read items, ignored observations and observations that fill a free slot:
//  ST_DONE loads the output register once it is free, then ST_IDLE takes the next item
//  a replacement: ST_DRAW draws, ST_DIV_GO starts the radix-2 remainder unit for its
//  64 steps in ST_DIV_WAIT, and ST_DONE hands the result off to the output register
//  after reset and after every capacity or seed write the generator is
//  reseeded: four splitmix64 rounds through the shared 32x32 multiplier, during
//  which in_stall_o is high
//  one item is in flight at a time; a finished result sits in the output
//  register, and a new item is taken while it waits for out_stall_i to drop

module reservoir_sampler_xoshiro_top #(
  parameter int MAX_SLOTS = rsx_pkg::DEFAULT_MAX_SLOTS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // input channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          kind_i,
  input  logic [rsx_pkg::DATA_W-1:0]    timestamp_i,
  input  logic [rsx_pkg::DATA_W-1:0]    payload_i,
  input  logic                          has_data_i,
  input  logic [rsx_pkg::SLOT_W-1:0]    slot_index_i,
  // output channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          stored_o,
  output logic [rsx_pkg::SLOT_W-1:0]    written_slot_o,
  output logic [rsx_pkg::CAP_W-1:0]     fill_level_o,
  output logic                          read_valid_o,
  output logic [rsx_pkg::DATA_W-1:0]    read_time_o,
  output logic [rsx_pkg::DATA_W-1:0]    read_data_o,
  // configuration writes
  input  logic                          cfg_we_i,
  input  logic [rsx_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [rsx_pkg::DATA_W-1:0]    cfg_wdata_i
);
  import rsx_pkg::*;

  localparam int MEM_AW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;

  // sequencer
  rsx_state_e state_q, state_d;

  // configuration and counters
  logic [CAP_W-1:0]  cap_q, cap_eff;
  logic [DATA_W-1:0] seed_q;
  logic [CAP_W-1:0]  filled_q;
  logic [DATA_W-1:0] seen_q, seen_inc;

  // splitmix expansion
  logic [DATA_W-1:0] acc_q, mix_sum, z_q;
  logic [1:0]        wi_q;

  // generator state
  logic [DATA_W-1:0] rng_q [4];
  logic [DATA_W-1:0] t5, tmp_q, dividend;
  logic [DATA_W-1:0] xs2, xs3;

  // item in flight
  logic [DATA_W-1:0] ts_q, pl_q;
  logic              stored_q, rd_valid_q;
  logic [CAP_W-1:0]  wslot_q;

  // output register
  logic              out_valid_q;
  logic              out_stored_q, out_rd_valid_q;
  logic [SLOT_W-1:0] out_wslot_q;
  logic [CAP_W-1:0]  out_fill_q;
  logic [DATA_W-1:0] out_time_q, out_data_q;

  // shared units
  logic              mul_start, mul_done;
  logic [DATA_W-1:0] mul_b, mul_p;
  logic              div_start, div_done;
  logic [DATA_W-1:0] div_rem;

  // slot memory
  slot_entry_t            mem_q [MAX_SLOTS];
  slot_entry_t            rdata_q;
  logic                   mem_we;
  logic [SLOT_EXT_W-1:0]  wslot_ext, rslot_ext;
  logic [MEM_AW-1:0]      waddr, raddr;

  // decode
  logic cfg_hit, in_acc, out_load;
  logic obs_take, fill_path, rd_ok, pick_hit;

  assign cfg_hit = cfg_we_i && (cfg_index_i == CFG_CAPACITY || cfg_index_i == CFG_SEED);

  // capacity above the slot count acts as the slot count
  assign cap_eff = ({{(SLOT_EXT_W - CAP_W){1'b0}}, cap_q} > SLOT_EXT_W'(MAX_SLOTS))
                   ? CAP_W'(MAX_SLOTS) : cap_q;

  assign in_acc    = in_valid_i && !in_stall_o;
  assign obs_take  = (kind_i == KIND_OBSERVE) && has_data_i && (cap_eff != '0);
  assign fill_path = filled_q < cap_eff;
  assign seen_inc  = (&seen_q) ? seen_q : seen_q + 1'b1;   // saturates, never wraps to zero

  assign rslot_ext = SLOT_EXT_W'(slot_index_i);
  assign rd_ok     = (kind_i == KIND_READ)
                     && ({1'b0, slot_index_i} < filled_q)
                     && (rslot_ext < SLOT_EXT_W'(MAX_SLOTS));
  assign raddr     = rslot_ext[MEM_AW-1:0];
  assign wslot_ext = SLOT_EXT_W'(wslot_q);
  assign waddr     = wslot_ext[MEM_AW-1:0];

  assign mix_sum  = acc_q + MIX_GOLDEN;
  assign mul_b    = (state_q == ST_SEED_M1GO) ? MIX_MUL1 : MIX_MUL2;

  // xoshiro256** scramble: rotl(s1 * 5, 7) here, times 9 when the divider starts
  assign t5       = rng_q[1] + {rng_q[1][DATA_W-3:0], 2'b00};
  assign dividend = tmp_q + {tmp_q[DATA_W-4:0], 3'b000};
  assign xs2      = rng_q[2] ^ rng_q[0];
  assign xs3      = rng_q[3] ^ rng_q[1];

  assign pick_hit = div_rem < DATA_W'(cap_eff);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_SEED_ADD:    state_d = ST_SEED_M1GO;
      ST_SEED_M1GO:   state_d = ST_SEED_M1WAIT;
      ST_SEED_M1WAIT: if (mul_done) state_d = ST_SEED_M2GO;
      ST_SEED_M2GO:   state_d = ST_SEED_M2WAIT;
      ST_SEED_M2WAIT: begin
        if (mul_done) begin
          state_d = (wi_q == 2'd3) ? ST_IDLE : ST_SEED_ADD;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          // only an observation into a full reservoir needs a draw
          state_d = (obs_take && !fill_path) ? ST_DRAW : ST_DONE;
        end
      end
      ST_DRAW:     state_d = ST_DIV_GO;
      ST_DIV_GO:   state_d = ST_DIV_WAIT;
      ST_DIV_WAIT: if (div_done) state_d = ST_DONE;
      ST_DONE:     if (!out_valid_q || !out_stall_i) state_d = ST_IDLE;
      default:     state_d = ST_SEED_ADD;
    endcase
    // a capacity or seed write restarts the seeding rounds
    if (cfg_hit) begin
      state_d = ST_SEED_ADD;
    end
  end

  // sequencer outputs
  always_comb begin
    in_stall_o = (state_q != ST_IDLE);
    mul_start  = (state_q == ST_SEED_M1GO) || (state_q == ST_SEED_M2GO);
    div_start  = (state_q == ST_DIV_GO);
    out_load   = (state_q == ST_DONE) && (!out_valid_q || !out_stall_i);
    mem_we     = out_load && stored_q;
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_SEED_ADD;
      cap_q       <= CAP_RESET;
      seed_q      <= '0;
      acc_q       <= '0;
      wi_q        <= '0;
      filled_q    <= '0;
      seen_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_hit) begin
        filled_q <= '0;
        seen_q   <= '0;
        wi_q     <= '0;
        case (cfg_index_i)
          CFG_CAPACITY: begin
            cap_q <= cfg_wdata_i[CAP_W-1:0];
            acc_q <= seed_q;
          end
          CFG_SEED: begin
            seed_q <= cfg_wdata_i;
            acc_q  <= cfg_wdata_i;
          end
          default: ;
        endcase
      end else begin
        if (state_q == ST_SEED_ADD) begin
          acc_q <= mix_sum;
        end
        if (state_q == ST_SEED_M2WAIT && mul_done) begin
          wi_q <= wi_q + 2'd1;
        end
        if (in_acc && obs_take) begin
          seen_q <= seen_inc;
          if (fill_path) begin
            filled_q <= filled_q + 1'b1;
          end
        end
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    // splitmix64 rounds
    if (state_q == ST_SEED_ADD) begin
      z_q <= mix_sum ^ (mix_sum >> 30);
    end
    if (state_q == ST_SEED_M1WAIT && mul_done) begin
      z_q <= mul_p ^ (mul_p >> 27);
    end
    if (state_q == ST_SEED_M2WAIT && mul_done) begin
      rng_q[wi_q] <= mul_p ^ (mul_p >> 31);
    end

    // capture the item at its transfer
    if (in_acc) begin
      ts_q       <= timestamp_i;
      pl_q       <= payload_i;
      stored_q   <= obs_take && fill_path;
      wslot_q    <= filled_q;
      rd_valid_q <= rd_ok;
    end

    // draw and advance the generator
    if (state_q == ST_DRAW) begin
      tmp_q    <= rotl64(t5, 7);
      rng_q[0] <= rng_q[0] ^ xs3;
      rng_q[1] <= rng_q[1] ^ xs2;
      rng_q[2] <= xs2 ^ (rng_q[1] << XO_SHIFT);
      rng_q[3] <= rotl64(xs3, XO_ROT);
    end

    // replacement: slot picked by draw mod seen, kept only below capacity
    if (state_q == ST_DIV_WAIT && div_done) begin
      stored_q <= pick_hit;
      wslot_q  <= div_rem[CAP_W-1:0];
    end

    if (out_load) begin
      out_stored_q   <= stored_q;
      out_wslot_q    <= stored_q ? wslot_q[SLOT_W-1:0] : '0;
      out_fill_q     <= filled_q;
      out_rd_valid_q <= rd_valid_q;
      out_time_q     <= rd_valid_q ? rdata_q.stamp : '0;
      out_data_q     <= rd_valid_q ? rdata_q.word : '0;
    end
  end

  // slot memory, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[waddr] <= '{stamp: ts_q, word: pl_q};
    end
    if (in_acc) begin
      rdata_q <= mem_q[raddr];
    end
  end

  rsx_mul64lo u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (z_q),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .prod_o  (mul_p)
  );

  rsx_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dividend),
    .divisor_i  (seen_q),
    .done_o     (div_done),
    .rem_o      (div_rem)
  );

  assign out_valid_o    = out_valid_q;
  assign stored_o       = out_stored_q;
  assign written_slot_o = out_wslot_q;
  assign fill_level_o   = out_fill_q;
  assign read_valid_o   = out_rd_valid_q;
  assign read_time_o    = out_time_q;
  assign read_data_o    = out_data_q;

  // fill count never passes the effective capacity
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    filled_q <= cap_eff)
    else $error("fill count above capacity");

  // the modulus is never zero
  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> seen_q != '0)
    else $error("division by zero seen count");

  // a result reports either a store or a read, and a store leaves a filled slot
  a_out_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_stored_q |-> !out_rd_valid_q && out_fill_q != '0)
    else $error("store result inconsistent");

  // capacity and seed writes clear the counters and reseed
  a_cfg_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_hit |=> state_q == ST_SEED_ADD && filled_q == '0 && seen_q == '0 && wi_q == '0)
    else $error("register write did not restart seeding");

endmodule
